[rtl/tfn_pkg.sv]
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared widths, payload types and status structs of the face normal unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tfn_pkg;

   // field widths
   localparam int COORD_W   = 24;
   localparam int FRAC_BITS = 14;
   localparam int NRM_W     = 16;

   // internal arithmetic widths
   localparam int NORM_BITS = 30;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int CROSS_W   = 2 * DIFF_W + 1;
   localparam int MAG_W     = 2 * DIFF_W;
   localparam int MUL_W     = NORM_BITS + 1;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int SQ_W      = 2 * NORM_BITS + 2;
   localparam int ROOT_W    = NORM_BITS + 1;
   localparam int QUO_W     = FRAC_BITS + 2;
   localparam int DIV_W     = ROOT_W + QUO_W;
   localparam int QCNT_W    = $clog2(QUO_W);

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [NRM_W-1:0]   normal_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
      coord_type u;
      coord_type v;
   } vertex_type;

   // index 0 is the first vertex of the triangle
   typedef vertex_type [2:0] tri_type;

   typedef struct packed {
      logic    valid;
      tri_type data;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   typedef struct packed {
      coord_type  out_x;
      coord_type  out_y;
      coord_type  out_z;
      coord_type  out_u;
      coord_type  out_v;
      normal_type normal_x;
      normal_type normal_y;
      normal_type normal_z;
      logic       last;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/tfn_channels.sv]
// ----------------------------------------------------------------------------
// tfn channels
// Valid/ready channel interfaces for vertex requests and vertex results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfn_req_if;
   logic              valid;
   logic              ready;
   tfn_pkg::coord_type pos_x;
   tfn_pkg::coord_type pos_y;
   tfn_pkg::coord_type pos_z;
   tfn_pkg::coord_type tex_u;
   tfn_pkg::coord_type tex_v;

   modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface tfn_rsp_if;
   logic                valid;
   logic                ready;
   tfn_pkg::coord_type  out_x;
   tfn_pkg::coord_type  out_y;
   tfn_pkg::coord_type  out_z;
   tfn_pkg::coord_type  out_u;
   tfn_pkg::coord_type  out_v;
   tfn_pkg::normal_type normal_x;
   tfn_pkg::normal_type normal_y;
   tfn_pkg::normal_type normal_z;
   logic                last;

   modport source (output valid, out_x, out_y, out_z, out_u, out_v,
                   normal_x, normal_y, normal_z, last, input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_u, out_v,
                   normal_x, normal_y, normal_z, last, output ready);
endinterface

`default_nettype wire

[rtl/tfn_front.sv]
// ----------------------------------------------------------------------------
// tfn_front
// Accepts vertex requests, holds the first two of each triangle and pushes
// the complete triangle into the queue on the third.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   tfn_req_if.sink                     req,
   input  wire tfn_pkg::fifo_stat_type stat,
   output tfn_pkg::push_type           push
);

   tfn_pkg::vertex_type held_ff [2];
   logic [1:0]          cnt_ff;
   logic [1:0]          cnt_in;
   tfn_pkg::vertex_type vtx;
   logic                accept;

   // request handshake
   assign req.ready = !stat.full;
   assign accept    = req.valid && req.ready;
   assign vtx       = '{x: req.pos_x, y: req.pos_y, z: req.pos_z,
                        u: req.tex_u, v: req.tex_v};

   // triangle push on the third vertex
   always_comb begin
      push.valid   = accept && cnt_ff[1];
      push.data[0] = held_ff[0];
      push.data[1] = held_ff[1];
      push.data[2] = vtx;
      cnt_in       = cnt_ff;
      if (accept) begin
         cnt_in = cnt_ff[1] ? 2'd0 : cnt_ff + 2'd1;
      end
   end

   // vertex count
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // held vertices
   always_ff @(posedge clock) begin
      if (accept && !cnt_ff[1]) begin
         held_ff[cnt_ff[0]] <= vtx;
      end
   end

endmodule

`default_nettype wire

[rtl/tfn_fifo.sv]
// ----------------------------------------------------------------------------
// tfn_fifo
// Two-entry triangle queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tfn_pkg::push_type push,
   input  wire logic              pop,
   output tfn_pkg::tri_type       head,
   output tfn_pkg::fifo_stat_type stat
);

   tfn_pkg::tri_type mem_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             do_push;
   logic             do_pop;

   assign stat.full  = count_ff[1];
   assign stat.empty = (count_ff == 2'd0);
   assign do_push    = push.valid && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = mem_ff[rd_ptr_ff];

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.data;
      end
   end

endmodule

`default_nettype wire

[rtl/tfn_back.sv]
// ----------------------------------------------------------------------------
// tfn_back
// Computes the face normal of one queued triangle with a shared multiplier,
// a shift normalizer, a bit-serial square root and a restoring divider, then
// sends its three vertices out through the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire tfn_pkg::tri_type       head,
   input  wire tfn_pkg::fifo_stat_type stat,
   output logic                        pop,
   tfn_rsp_if.source                   rsp
);

   localparam int DW   = tfn_pkg::DIFF_W;
   localparam int CW   = tfn_pkg::CROSS_W;
   localparam int MW   = tfn_pkg::MAG_W;
   localparam int UW   = tfn_pkg::MUL_W;
   localparam int PW   = tfn_pkg::PROD_W;
   localparam int SW   = tfn_pkg::SQ_W;
   localparam int RW   = tfn_pkg::ROOT_W;
   localparam int QW   = tfn_pkg::QUO_W;
   localparam int VW   = tfn_pkg::DIV_W;
   localparam int NB   = tfn_pkg::NORM_BITS;
   localparam int FB   = tfn_pkg::FRAC_BITS;
   localparam int NW   = tfn_pkg::NRM_W;
   localparam int CNW  = tfn_pkg::QCNT_W;
   localparam int XW   = NW + QW;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_MUL   = 9'b000000010,
      ST_ABS   = 9'b000000100,
      ST_NORM  = 9'b000001000,
      ST_SQR   = 9'b000010000,
      ST_SQRT  = 9'b000100000,
      ST_DLOAD = 9'b001000000,
      ST_DIV   = 9'b010000000,
      ST_EMIT  = 9'b100000000
   } state_type;

   state_type           state_ff, state_in;
   tfn_pkg::tri_type    tri_ff, tri_in;
   logic signed [DW-1:0] ab_ff [3];
   logic signed [DW-1:0] ac_ff [3];
   logic signed [DW-1:0] ab_in [3];
   logic signed [DW-1:0] ac_in [3];
   logic signed [CW-1:0] acc_ff [3];
   logic signed [CW-1:0] acc_in [3];
   logic [MW-1:0]        mag_ff [3];
   logic [MW-1:0]        mag_in [3];
   logic [2:0]           neg_ff, neg_in;
   logic [3:0]           step_ff, step_in;
   logic signed [UW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic [SW-1:0]        sum_ff, sum_in;
   logic [SW-1:0]        root_ff, root_in;
   logic [SW-1:0]        bit_ff, bit_in;
   logic [VW-1:0]        rem_ff, rem_in;
   logic [VW-1:0]        den_ff, den_in;
   logic [QW-1:0]        q_ff, q_in;
   logic [CNW-1:0]       qcnt_ff, qcnt_in;
   logic [1:0]           comp_ff, comp_in;
   logic [NW-1:0]        nrm_ff [3];
   logic [NW-1:0]        nrm_in [3];
   logic [1:0]           k_ff, k_in;
   logic                 vld_ff, vld_in;
   tfn_pkg::rsp_type     out_ff, out_in;

   logic [MW-1:0]        mag_or;
   logic [SW-1:0]        trial;
   logic [RW-1:0]        root_r;
   logic                 ge;
   logic [QW-1:0]        qf, qc;
   logic [XW-1:0]        qx;
   logic [3:0]           sidx;
   tfn_pkg::vertex_type  ov;

   assign mag_or = mag_ff[0] | mag_ff[1] | mag_ff[2];
   assign trial  = root_ff + bit_ff;
   assign root_r = root_ff[RW-1:0];
   assign ge     = (rem_ff >= den_ff);
   assign sidx   = step_ff - 4'd1;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_SQR) begin
         unique case (step_ff)
            4'd0: begin
               mul_a = UW'({1'b0, mag_ff[0][NB-1:0]});
            end
            4'd1: begin
               mul_a = UW'({1'b0, mag_ff[1][NB-1:0]});
            end
            default: begin
               mul_a = UW'({1'b0, mag_ff[2][NB-1:0]});
            end
         endcase
         mul_b = mul_a;
      end else begin
         unique case (step_ff)
            4'd0: begin
               mul_a = UW'(ab_ff[1]);
               mul_b = UW'(ac_ff[2]);
            end
            4'd1: begin
               mul_a = UW'(ab_ff[2]);
               mul_b = UW'(ac_ff[1]);
            end
            4'd2: begin
               mul_a = UW'(ab_ff[2]);
               mul_b = UW'(ac_ff[0]);
            end
            4'd3: begin
               mul_a = UW'(ab_ff[0]);
               mul_b = UW'(ac_ff[2]);
            end
            4'd4: begin
               mul_a = UW'(ab_ff[0]);
               mul_b = UW'(ac_ff[1]);
            end
            default: begin
               mul_a = UW'(ab_ff[1]);
               mul_b = UW'(ac_ff[0]);
            end
         endcase
      end
      prod_in = mul_a * mul_b;
   end

   // final quotient: clamp to one, apply sign, cut to the field
   always_comb begin
      qf = {q_ff[QW-2:0], ge};
      qc = (qf > (QW'(1) << FB)) ? (QW'(1) << FB) : qf;
      qx = XW'(qc);
      if (neg_ff[comp_ff]) begin
         qx = -qx;
      end
   end

   assign ov = tri_ff[k_ff];

   // sequencer
   always_comb begin
      state_in = state_ff;
      tri_in   = tri_ff;
      ab_in    = ab_ff;
      ac_in    = ac_ff;
      acc_in   = acc_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      step_in  = step_ff;
      sum_in   = sum_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      q_in     = q_ff;
      qcnt_in  = qcnt_ff;
      comp_in  = comp_ff;
      nrm_in   = nrm_ff;
      k_in     = k_ff;
      vld_in   = vld_ff && !rsp.ready;
      out_in   = out_ff;
      pop      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!stat.empty) begin
               pop    = 1'b1;
               tri_in = head;
               ab_in[0] = DW'(head[0].x) - DW'(head[1].x);
               ab_in[1] = DW'(head[0].y) - DW'(head[1].y);
               ab_in[2] = DW'(head[0].z) - DW'(head[1].z);
               ac_in[0] = DW'(head[0].x) - DW'(head[2].x);
               ac_in[1] = DW'(head[0].y) - DW'(head[2].y);
               ac_in[2] = DW'(head[0].z) - DW'(head[2].z);
               for (int i = 0; i < 3; i++) begin
                  acc_in[i] = '0;
               end
               step_in  = 4'd0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // each product is registered in prod_ff and accumulated from there
            if (step_ff != 4'd0) begin
               if (sidx[0]) begin
                  acc_in[sidx[2:1]] = acc_ff[sidx[2:1]] - CW'(prod_ff);
               end else begin
                  acc_in[sidx[2:1]] = acc_ff[sidx[2:1]] + CW'(prod_ff);
               end
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd6) begin
               state_in = ST_ABS;
            end
         end
         ST_ABS: begin
            for (int i = 0; i < 3; i++) begin
               neg_in[i] = acc_ff[i][CW-1];
               mag_in[i] = acc_ff[i][CW-1] ? MW'(-acc_ff[i]) : MW'(acc_ff[i]);
            end
            state_in = ST_NORM;
         end
         ST_NORM: begin
            // one bit of common shift a cycle until the top sits at bit NB-1
            if (mag_or == '0) begin
               for (int i = 0; i < 3; i++) begin
                  nrm_in[i] = '0;
               end
               k_in     = 2'd0;
               state_in = ST_EMIT;
            end else if (mag_or[MW-1:NB] != '0) begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = mag_ff[i] >> 1;
               end
            end else if (!mag_or[NB-1]) begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = mag_ff[i] << 1;
               end
            end else begin
               step_in  = 4'd0;
               sum_in   = '0;
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            if (step_ff != 4'd0) begin
               sum_in = sum_ff + SW'(prod_ff);
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd3) begin
               root_in  = '0;
               bit_in   = SW'(1) << (SW - 2);
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            // one result bit a cycle
            if (sum_ff >= trial) begin
               sum_in  = sum_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               comp_in  = 2'd0;
               state_in = ST_DLOAD;
            end
         end
         ST_DLOAD: begin
            rem_in   = VW'({mag_ff[comp_ff][NB-1:0], {FB{1'b0}}}) + VW'(root_r >> 1);
            den_in   = VW'(root_r) << (QW - 1);
            q_in     = '0;
            qcnt_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // restoring division, one quotient bit a cycle
            if (ge) begin
               rem_in = rem_ff - den_ff;
            end
            den_in  = den_ff >> 1;
            q_in    = qf;
            qcnt_in = qcnt_ff + CNW'(1);
            if (qcnt_ff == CNW'(QW - 1)) begin
               nrm_in[comp_ff] = qx[NW-1:0];
               if (comp_ff == 2'd2) begin
                  k_in     = 2'd0;
                  state_in = ST_EMIT;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = ST_DLOAD;
               end
            end
         end
         ST_EMIT: begin
            if (!vld_ff || rsp.ready) begin
               vld_in          = 1'b1;
               out_in.out_x    = ov.x;
               out_in.out_y    = ov.y;
               out_in.out_z    = ov.z;
               out_in.out_u    = ov.u;
               out_in.out_v    = ov.v;
               out_in.normal_x = nrm_ff[0];
               out_in.normal_y = nrm_ff[1];
               out_in.normal_z = nrm_ff[2];
               out_in.last     = (k_ff == 2'd2);
               if (k_ff == 2'd2) begin
                  k_in     = 2'd0;
                  state_in = ST_IDLE;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vld_ff   <= 1'b0;
         k_ff     <= 2'd0;
         step_ff  <= 4'd0;
         comp_ff  <= 2'd0;
         qcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         k_ff     <= k_in;
         step_ff  <= step_in;
         comp_ff  <= comp_in;
         qcnt_ff  <= qcnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      tri_ff  <= tri_in;
      ab_ff   <= ab_in;
      ac_ff   <= ac_in;
      acc_ff  <= acc_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
      nrm_ff  <= nrm_in;
      out_ff  <= out_in;
   end

   // result port
   assign rsp.valid    = vld_ff;
   assign rsp.out_x    = out_ff.out_x;
   assign rsp.out_y    = out_ff.out_y;
   assign rsp.out_z    = out_ff.out_z;
   assign rsp.out_u    = out_ff.out_u;
   assign rsp.out_v    = out_ff.out_v;
   assign rsp.normal_x = out_ff.normal_x;
   assign rsp.normal_y = out_ff.normal_y;
   assign rsp.normal_z = out_ff.normal_z;
   assign rsp.last     = out_ff.last;

   // checks
   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> {1'b0, rem_ff} < {den_ff, 1'b0})
      else $error("divider remainder out of range");

   a_norm_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SQR |-> (mag_or[MW-1:NB] == '0 && mag_or[NB-1]))
      else $error("magnitudes not normalized before squaring");

   a_idle_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> k_ff == 2'd0)
      else $error("vertex index left nonzero at idle");

endmodule

`default_nettype wire

[rtl/triangle_face_normal_unit.sv]
// ----------------------------------------------------------------------------
// triangle_face_normal_unit
// Per-triangle face normal: vertices in, vertices with a Q1.14 normal out.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan takes one vertex request per valid/ready handshake, three per
//   triangle in order. The first two are held in the front; the third pushes
//   the whole triangle into a two-entry queue, so the front keeps taking
//   requests while the back works.
//   rsp_chan returns the three vertices of each triangle in order, each with
//   the face normal of (A-B) x (A-C), last set on the third.
//   The back works on one triangle at a time: six cross products on one
//   shared multiplier, one-bit normalizing shifts, the sum of squares, the
//   square root (one bit a cycle) and three divisions, then it loads the
//   three results.
//   A degenerate triangle skips straight to the results with a zero normal.
//   Reset (synchronous, active high) clears the vertex count, the queue and
//   the result valid flag. When rsp_chan stalls, the result register holds
//   its vertex, the back waits and the queue and front fill up.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_face_normal_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   tfn_req_if.sink     req_chan,
   tfn_rsp_if.source   rsp_chan
);

   tfn_pkg::push_type      push;
   tfn_pkg::fifo_stat_type stat;
   tfn_pkg::tri_type       head;
   logic                   pop;

   // vertex intake
   tfn_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .stat  (stat),
      .push  (push)
   );

   // triangle queue
   tfn_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .stat  (stat)
   );

   // normal computation and result output
   tfn_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .stat  (stat),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule

`default_nettype wire

[dv/tfn_normal_checker.sv]
// ----------------------------------------------------------------------------
// tfn_normal_checker
// Watches the vertex request and result channels, predicts each triangle's
// three output vertices with their face normal, and compares in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_normal_checker (
   input  wire logic  clock,
   input  wire logic  reset,
   tfn_req_if         req_mon,
   tfn_rsp_if         rsp_mon,
   output int         error_count,
   output int         pending_count
);

   // predicted vertices still to come out
   tfn_pkg::rsp_type expected_vertices[$];

   tfn_pkg::vertex_type held_vertex[2];
   int unsigned vertex_index;

   typedef struct {
      logic             neg;
      logic [64:0]      mag;
   } cross_type;

   // signed difference products, kept exact
   function automatic cross_type cross_term(longint p, longint q, longint r, longint s);
      logic signed [66:0] v;
      cross_type c;
      v = 67'(p) * 67'(q) - 67'(r) * 67'(s);
      c.neg = v < 0;
      c.mag = c.neg ? 65'(-v) : 65'(v);
      return c;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // unit normal of (a-b) x (a-c)
   function automatic void face_normal(tfn_pkg::vertex_type a, tfn_pkg::vertex_type b,
                                       tfn_pkg::vertex_type c,
                                       output tfn_pkg::normal_type nrm[3]);
      longint ab[3], ac[3];
      cross_type w[3];
      logic [63:0] mag[3], sumsq, r, q, one;
      int len, l;
      ab[0] = longint'(a.x) - longint'(b.x);
      ab[1] = longint'(a.y) - longint'(b.y);
      ab[2] = longint'(a.z) - longint'(b.z);
      ac[0] = longint'(a.x) - longint'(c.x);
      ac[1] = longint'(a.y) - longint'(c.y);
      ac[2] = longint'(a.z) - longint'(c.z);
      w[0] = cross_term(ab[1], ac[2], ab[2], ac[1]);
      w[1] = cross_term(ab[2], ac[0], ab[0], ac[2]);
      w[2] = cross_term(ab[0], ac[1], ab[1], ac[0]);
      len = 0;
      for (int i = 0; i < 3; i++) begin
         l = 0;
         for (int b2 = 0; b2 < 65; b2++) if (w[i].mag[b2]) l = b2 + 1;
         if (l > len) len = l;
      end
      if (len == 0) begin
         for (int i = 0; i < 3; i++) nrm[i] = '0;
         return;
      end
      sumsq = 0;
      for (int i = 0; i < 3; i++) begin
         if (len > tfn_pkg::NORM_BITS) begin
            mag[i] = 64'(w[i].mag >> (len - tfn_pkg::NORM_BITS));
         end else begin
            mag[i] = 64'(w[i].mag) << (tfn_pkg::NORM_BITS - len);
         end
         sumsq += mag[i] * mag[i];
      end
      r   = int_sqrt(sumsq);
      one = 64'd1 << tfn_pkg::FRAC_BITS;
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << tfn_pkg::FRAC_BITS) + (r >> 1)) / r;
         if (q > one) q = one;
         if (w[i].neg) q = -q;
         nrm[i] = q[15:0];
      end
   endfunction

   function automatic tfn_pkg::rsp_type vertex_result(tfn_pkg::vertex_type vx,
                                                      tfn_pkg::normal_type nrm[3],
                                                      logic lst);
      tfn_pkg::rsp_type rr;
      rr.out_x = vx.x;  rr.out_y = vx.y;  rr.out_z = vx.z;
      rr.out_u = vx.u;  rr.out_v = vx.v;
      rr.normal_x = nrm[0];  rr.normal_y = nrm[1];  rr.normal_z = nrm[2];
      rr.last = lst;
      return rr;
   endfunction

   // queue depth, sampled away from the rising edge
   always @(negedge clock) begin
      pending_count = expected_vertices.size();
   end

   // predict on each accepted request
   always @(posedge clock) begin
      tfn_pkg::vertex_type vin;
      tfn_pkg::normal_type nrm[3];
      if (reset) begin
         vertex_index <= 0;
      end else if (req_mon.valid && req_mon.ready) begin
         vin = '{req_mon.pos_x, req_mon.pos_y, req_mon.pos_z, req_mon.tex_u, req_mon.tex_v};
         if (vertex_index < 2) begin
            held_vertex[vertex_index] = vin;
            vertex_index <= vertex_index + 1;
         end else begin
            face_normal(held_vertex[0], held_vertex[1], vin, nrm);
            expected_vertices.push_back(vertex_result(held_vertex[0], nrm, 1'b0));
            expected_vertices.push_back(vertex_result(held_vertex[1], nrm, 1'b0));
            expected_vertices.push_back(vertex_result(vin, nrm, 1'b1));
            vertex_index <= 0;
         end
      end
   end

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      tfn_pkg::rsp_type got, want;
      if (reset) begin
         error_count <= 0;
      end else if (rsp_mon.valid && rsp_mon.ready) begin
         got = '{rsp_mon.out_x, rsp_mon.out_y, rsp_mon.out_z, rsp_mon.out_u, rsp_mon.out_v,
                 rsp_mon.normal_x, rsp_mon.normal_y, rsp_mon.normal_z, rsp_mon.last};
         if (expected_vertices.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            error_count <= error_count + 1;
         end else begin
            want = expected_vertices.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected %h actual %h", $time, want, got);
               $display("   pos exp %0d %0d %0d act %0d %0d %0d", want.out_x, want.out_y,
                        want.out_z, got.out_x, got.out_y, got.out_z);
               $display("   nrm exp %0d %0d %0d %b act %0d %0d %0d %b", want.normal_x,
                        want.normal_y, want.normal_z, want.last, got.normal_x,
                        got.normal_y, got.normal_z, got.last);
               error_count <= error_count + 1;
            end
         end
      end
   end

endmodule

`default_nettype wire

[dv/tb_triangle_face_normal_unit.sv]
// ----------------------------------------------------------------------------
// tb_triangle_face_normal_unit
// Drives vertex requests (directed corners, then random triangles) under
// varying idle and stall patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_triangle_face_normal_unit;

   logic clock;
   logic reset;
   int   error_count;
   int   pending_count;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   hold_off_cycles;
   int   cycle_count;

   tfn_req_if req_chan ();
   tfn_rsp_if rsp_chan ();

   triangle_face_normal_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   tfn_normal_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         rsp_chan.ready  <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("** triangle_face_normal_unit: FAILED **");
         $finish;
      end
   end

   function automatic tfn_pkg::coord_type rand_coord();
      case ($urandom_range(5))
         0: return tfn_pkg::coord_type'(24'h800000);
         1: return tfn_pkg::coord_type'(24'h7FFFFF);
         2: return tfn_pkg::coord_type'(int'($urandom_range(511)) - 256);
         default: return tfn_pkg::coord_type'($urandom);
      endcase
   endfunction

   // offer one vertex request and hold it until accepted
   task automatic send_vertex(tfn_pkg::coord_type px, py, pz, tu, tv);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.pos_x <= px;
      req_chan.pos_y <= py;
      req_chan.pos_z <= pz;
      req_chan.tex_u <= tu;
      req_chan.tex_v <= tv;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_random_triangle();
      tfn_pkg::coord_type p[3];
      for (int k = 0; k < 3; k++) begin
         p[0] = rand_coord();  p[1] = rand_coord();  p[2] = rand_coord();
         send_vertex(p[0], p[1], p[2], rand_coord(), rand_coord());
      end
   endtask

   // stop offering and wait until every predicted result has come out
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   initial begin
      tfn_pkg::coord_type mn, mx;
      mn = tfn_pkg::coord_type'(24'h800000);
      mx = tfn_pkg::coord_type'(24'h7FFFFF);
      reset           = 1'b1;
      cycle_count     = 0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      hold_off_cycles = 0;
      req_chan.valid  = 1'b0;
      req_chan.pos_x  = '0;
      req_chan.pos_y  = '0;
      req_chan.pos_z  = '0;
      req_chan.tex_u  = '0;
      req_chan.tex_v  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: degenerate, axis-aligned, extreme span, tiny span
      send_vertex(0, 0, 0, mn, mx);
      send_vertex(0, 0, 0, mx, mn);
      send_vertex(0, 0, 0, 0, 0);
      send_vertex(0, 0, 0, 1, 2);
      send_vertex(65536, 0, 0, 3, 4);
      send_vertex(0, 65536, 0, 5, 6);
      send_vertex(mn, mn, mn, mn, mn);
      send_vertex(mx, mn, mx, mx, mx);
      send_vertex(mn, mx, mx, -1, 1);
      send_vertex(mx, mx, mx, 0, 0);
      send_vertex(mn, mn, mx, 0, 0);
      send_vertex(mx, mn, mn, 0, 0);
      send_vertex(1, 2, 3, 0, 0);
      send_vertex(2, 4, 6, 0, 0);
      send_vertex(3, 6, 9, 0, 0);
      send_vertex(0, 0, 0, 0, 0);
      send_vertex(1, 0, 0, 0, 0);
      send_vertex(0, 0, 1, 0, 0);
      send_vertex(-5, 7, -9, mx, mn);
      send_vertex(-5, 7, -9, mn, mx);
      send_vertex(-4, 7, -9, 0, 0);

      // sender pauses until all results are back
      wait_drained();

      // long receiver hold-off while requests keep coming
      hold_off_cycles <= 600;
      for (int t = 0; t < 8; t++) send_random_triangle();
      wait_drained();

      // random phases of idling and stalling
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 71 : 35) : 0;
         recv_stall_pct = (ph == 2) ? 71 : (ph == 3) ? 35 : 0;
         for (int t = 0; t < 21; t++) send_random_triangle();
      end
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      wait_drained();
      repeat (200) @(posedge clock);

      if (error_count == 0 && pending_count == 0) begin
         $display("** triangle_face_normal_unit: PASSED **");
      end else begin
         $display("** triangle_face_normal_unit: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
